FILE: rtl/tx224_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TPKT / X.224 cookie extractor package
// Shared widths, event codes, character constants and literal tables.
// ----------------------------------------------------------------------------
package tx224_pkg;

   // Field widths.
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned EVENT_W  = 3;
   localparam int unsigned REMAIN_W = 16;
   localparam int unsigned INDEX_W  = 4;

   // Result event codes.
   typedef enum logic [EVENT_W-1:0] {
      EV_NONE      = 3'd0,
      EV_NAME      = 3'd1,
      EV_NAME_DONE = 3'd2,
      EV_FRAME_ERR = 3'd3,
      EV_X224_ERR  = 3'd4
   } event_type;

   // TPKT header constants.
   localparam logic [BYTE_W-1:0]   TPKT_VERSION  = 8'h03;
   localparam logic [BYTE_W-1:0]   TPKT_RESERVED = 8'h00;
   localparam logic [REMAIN_W-1:0] TPKT_HDR_LEN  = 16'd4;

   // X.224 constants.
   localparam logic [BYTE_W-1:0] X224_MIN_HLEN = 8'd2;
   localparam logic [3:0]        X224_CR_CODE  = 4'hE;

   // Characters.
   localparam logic [BYTE_W-1:0] CHAR_UPPER_C = 8'h43;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_M = 8'h4D;
   localparam logic [BYTE_W-1:0] CHAR_CR      = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF      = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_TAB     = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

   // Last index of each counted section.
   localparam logic [INDEX_W-1:0] SKIP_LAST   = 4'd4;
   localparam logic [INDEX_W-1:0] COOKIE_LAST = 4'd5;
   localparam logic [INDEX_W-1:0] MST_LAST    = 4'd8;

   // Remaining characters of "COOKIE:" after the leading C.
   function automatic logic [BYTE_W-1:0] cookie_char(input logic [INDEX_W-1:0] idx);
      logic [BYTE_W-1:0] c;
      unique case (idx)
         4'd0:    c = 8'h4F;   // O
         4'd1:    c = 8'h4F;   // O
         4'd2:    c = 8'h4B;   // K
         4'd3:    c = 8'h49;   // I
         4'd4:    c = 8'h45;   // E
         default: c = 8'h3A;   // colon
      endcase
      return c;
   endfunction

   // Characters of "MSTSHASH=".
   function automatic logic [BYTE_W-1:0] mst_char(input logic [INDEX_W-1:0] idx);
      logic [BYTE_W-1:0] c;
      unique case (idx)
         4'd0:    c = 8'h4D;   // M
         4'd1:    c = 8'h53;   // S
         4'd2:    c = 8'h54;   // T
         4'd3:    c = 8'h53;   // S
         4'd4:    c = 8'h48;   // H
         4'd5:    c = 8'h41;   // A
         4'd6:    c = 8'h53;   // S
         4'd7:    c = 8'h48;   // H
         default: c = 8'h3D;   // equals sign
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/tx224_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stream byte request channel
// Valid/ready channel that carries one stream byte per request.
// ----------------------------------------------------------------------------
interface tx224_req_if;
   logic                           valid;
   logic                           ready;
   logic [tx224_pkg::BYTE_W-1:0]   data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/tx224_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Extractor result channel
// Valid/ready channel that carries one parse result per request.
// ----------------------------------------------------------------------------
interface tx224_rsp_if;
   logic                           valid;
   logic                           ready;
   tx224_pkg::event_type           event_res;
   logic [tx224_pkg::BYTE_W-1:0]   name_byte;
   logic                           packet_end;

   modport source (output valid, output event_res, output name_byte, output packet_end,
                   input ready);
   modport sink (input valid, input event_res, input name_byte, input packet_end,
                 output ready);
endinterface
`default_nettype wire

FILE: rtl/tpkt_x224_cookie_extractor_core.sv
// Usage: bytes of one direction of a TCP stream enter on req_bus, one byte per
// request. Every request produces exactly one result on rsp_bus: an event code
// (none, name byte, name complete, framing error, X.224 error), the cookie name
// byte when the event is a name byte, and a flag marking the last byte of a
// TPKT packet. The parser state is updated in the cycle a request is accepted,
// and the result is held in an output register for the next cycle; throughput
// is one byte per cycle while unstalled. The result register is the only stage:
// a new request is taken whenever it is empty or is being drained in the same
// cycle. When the receiver stalls, the held result stays put and req_bus.ready
// drops until it is taken. Reset returns the TPKT framer to the version byte,
// the X.224 parser to the header length and empties the result register.
// A framing error locks the framer until the next reset.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TPKT / X.224 connection request cookie extractor
// Frames TPKT packets and pulls the mstshash cookie name out of X.224
// connection requests, one stream byte per cycle unless the receiver stalls.
// ----------------------------------------------------------------------------
module tpkt_x224_cookie_extractor_core (
   input  wire logic     clock,
   input  wire logic     reset,
   tx224_req_if.sink     req_bus,
   tx224_rsp_if.source   rsp_bus
);

   // TPKT framer states.
   typedef enum logic [5:0] {
      TP_VERSION  = 6'b000001,
      TP_RESERVED = 6'b000010,
      TP_LEN_HI   = 6'b000100,
      TP_LEN_LO   = 6'b001000,
      TP_PAYLOAD  = 6'b010000,
      TP_LOCKED   = 6'b100000
   } tpkt_state_type;

   // X.224 parser states.
   typedef enum logic [8:0] {
      XS_HLEN   = 9'b000000001,
      XS_CODE   = 9'b000000010,
      XS_SKIP   = 9'b000000100,
      XS_FIRSTC = 9'b000001000,
      XS_COOKIE = 9'b000010000,
      XS_WS     = 9'b000100000,
      XS_MST    = 9'b001000000,
      XS_NAME   = 9'b010000000,
      XS_IGNORE = 9'b100000000
   } x224_state_type;

   tpkt_state_type                      tpkt_state_ff, tpkt_state_in;
   x224_state_type                      x224_state_ff, x224_state_in;
   logic [tx224_pkg::REMAIN_W-1:0]      remain_ff, remain_in;
   logic [tx224_pkg::INDEX_W-1:0]       index_ff, index_in;

   logic                                rsp_valid_ff;
   tx224_pkg::event_type                event_ff, event_in;
   logic [tx224_pkg::BYTE_W-1:0]        name_ff, name_in;
   logic                                pend_ff, pend_in;

   logic                                accept;
   logic [tx224_pkg::BYTE_W-1:0]        in_byte;
   logic [tx224_pkg::BYTE_W-1:0]        up_byte;
   logic                                is_space;
   logic [tx224_pkg::REMAIN_W-1:0]      total_len;

   // Handshake: take a request when the result register is free or draining.
   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign in_byte       = req_bus.data_byte;

   // Case folding and whitespace detection.
   assign up_byte  = (in_byte >= tx224_pkg::CHAR_LOWER_A && in_byte <= tx224_pkg::CHAR_LOWER_Z)
                     ? (in_byte - tx224_pkg::CASE_OFFSET) : in_byte;
   assign is_space = (in_byte == tx224_pkg::CHAR_SPACE) ||
                     (in_byte >= tx224_pkg::CHAR_TAB && in_byte <= tx224_pkg::CHAR_CR);

   // Full packet length from the stored high byte and the current low byte.
   assign total_len = {remain_ff[tx224_pkg::REMAIN_W-1:tx224_pkg::BYTE_W], in_byte};

   // Next-state and result logic for one request.
   always_comb begin
      tpkt_state_in = tpkt_state_ff;
      x224_state_in = x224_state_ff;
      remain_in     = remain_ff;
      index_in      = index_ff;
      event_in      = tx224_pkg::EV_NONE;
      name_in       = '0;
      pend_in       = 1'b0;

      unique case (tpkt_state_ff)
         TP_VERSION: begin
            if (in_byte != tx224_pkg::TPKT_VERSION) begin
               tpkt_state_in = TP_LOCKED;
               event_in      = tx224_pkg::EV_FRAME_ERR;
            end else begin
               tpkt_state_in = TP_RESERVED;
            end
         end
         TP_RESERVED: begin
            if (in_byte != tx224_pkg::TPKT_RESERVED) begin
               tpkt_state_in = TP_LOCKED;
               event_in      = tx224_pkg::EV_FRAME_ERR;
            end else begin
               tpkt_state_in = TP_LEN_HI;
            end
         end
         TP_LEN_HI: begin
            remain_in     = {in_byte, {tx224_pkg::BYTE_W{1'b0}}};
            tpkt_state_in = TP_LEN_LO;
         end
         TP_LEN_LO: begin
            if (total_len < tx224_pkg::TPKT_HDR_LEN) begin
               tpkt_state_in = TP_LOCKED;
               event_in      = tx224_pkg::EV_FRAME_ERR;
            end else begin
               remain_in     = total_len - tx224_pkg::TPKT_HDR_LEN;
               x224_state_in = XS_HLEN;
               index_in      = '0;
               if (total_len == tx224_pkg::TPKT_HDR_LEN) begin
                  tpkt_state_in = TP_VERSION;
                  pend_in       = 1'b1;
               end else begin
                  tpkt_state_in = TP_PAYLOAD;
               end
            end
         end
         TP_PAYLOAD: begin
            // Count the payload down and close the packet on its last byte.
            if (remain_ff != '0) begin
               remain_in = remain_ff - 1'b1;
            end
            if (remain_ff <= {{(tx224_pkg::REMAIN_W-1){1'b0}}, 1'b1}) begin
               tpkt_state_in = TP_VERSION;
               pend_in       = 1'b1;
            end

            // X.224 connection request parser.
            unique case (x224_state_ff)
               XS_HLEN: begin
                  if (in_byte < tx224_pkg::X224_MIN_HLEN) begin
                     x224_state_in = XS_IGNORE;
                     event_in      = tx224_pkg::EV_X224_ERR;
                  end else begin
                     x224_state_in = XS_CODE;
                  end
               end
               XS_CODE: begin
                  if (in_byte[7:4] == tx224_pkg::X224_CR_CODE) begin
                     x224_state_in = XS_SKIP;
                     index_in      = '0;
                  end else begin
                     x224_state_in = XS_IGNORE;
                  end
               end
               XS_SKIP: begin
                  if (index_ff == tx224_pkg::SKIP_LAST) begin
                     x224_state_in = XS_FIRSTC;
                  end else begin
                     index_in = index_ff + 1'b1;
                  end
               end
               XS_FIRSTC: begin
                  // Only an exact uppercase C starts a cookie.
                  if (in_byte == tx224_pkg::CHAR_UPPER_C) begin
                     x224_state_in = XS_COOKIE;
                     index_in      = '0;
                  end else begin
                     x224_state_in = XS_IGNORE;
                  end
               end
               XS_COOKIE: begin
                  if (up_byte != tx224_pkg::cookie_char(index_ff)) begin
                     x224_state_in = XS_IGNORE;
                     event_in      = tx224_pkg::EV_X224_ERR;
                  end else if (index_ff == tx224_pkg::COOKIE_LAST) begin
                     x224_state_in = XS_WS;
                  end else begin
                     index_in = index_ff + 1'b1;
                  end
               end
               XS_WS: begin
                  // Skip whitespace; the first other byte must open the hash key.
                  if (!is_space) begin
                     if (up_byte != tx224_pkg::CHAR_UPPER_M) begin
                        x224_state_in = XS_IGNORE;
                        event_in      = tx224_pkg::EV_X224_ERR;
                     end else begin
                        x224_state_in = XS_MST;
                        index_in      = {{(tx224_pkg::INDEX_W-1){1'b0}}, 1'b1};
                     end
                  end
               end
               XS_MST: begin
                  if (up_byte != tx224_pkg::mst_char(index_ff)) begin
                     x224_state_in = XS_IGNORE;
                     event_in      = tx224_pkg::EV_X224_ERR;
                  end else if (index_ff == tx224_pkg::MST_LAST) begin
                     x224_state_in = XS_NAME;
                  end else begin
                     index_in = index_ff + 1'b1;
                  end
               end
               XS_NAME: begin
                  if (in_byte == tx224_pkg::CHAR_CR || in_byte == tx224_pkg::CHAR_LF) begin
                     x224_state_in = XS_IGNORE;
                     event_in      = tx224_pkg::EV_NAME_DONE;
                  end else begin
                     event_in = tx224_pkg::EV_NAME;
                     name_in  = in_byte;
                  end
               end
               XS_IGNORE: begin
                  x224_state_in = XS_IGNORE;
               end
               default: begin
                  x224_state_in = XS_IGNORE;
               end
            endcase
         end
         TP_LOCKED: begin
            tpkt_state_in = TP_LOCKED;
         end
         default: begin
            tpkt_state_in = TP_LOCKED;
         end
      endcase
   end

   // Parser state registers, advanced once per accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         tpkt_state_ff <= TP_VERSION;
         x224_state_ff <= XS_HLEN;
         remain_ff     <= '0;
         index_ff      <= '0;
      end else if (accept) begin
         tpkt_state_ff <= tpkt_state_in;
         x224_state_ff <= x224_state_in;
         remain_ff     <= remain_in;
         index_ff      <= index_in;
      end
   end

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         event_ff <= event_in;
         name_ff  <= name_in;
         pend_ff  <= pend_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.event_res  = event_ff;
   assign rsp_bus.name_byte  = name_ff;
   assign rsp_bus.packet_end = pend_ff;

endmodule
`default_nettype wire
